[src/rvh_pkg.sv]
// shared types, constants and helpers for the rgb and value histogram core
package rvh_pkg;

    localparam int COUNT_WIDTH = 32;
    localparam int NUM_BINS    = 256;
    localparam int BIN_W       = $clog2(NUM_BINS);
    localparam int PIX_W       = 8;
    localparam int OUT_W       = 32;
    localparam int NUM_LANES   = 4;

    localparam int LANE_RED   = 0;
    localparam int LANE_GREEN = 1;
    localparam int LANE_BLUE  = 2;
    localparam int LANE_VALUE = 3;

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [BIN_W-1:0]       bin_t;
    typedef logic [PIX_W-1:0]       pix_t;
    typedef logic [OUT_W-1:0]       out_count_t;
    typedef logic [1:0]             mode_t;

    localparam mode_t MODE_ACC   = 2'd0;
    localparam mode_t MODE_READ  = 2'd1;
    localparam mode_t MODE_CLEAR = 2'd2;

    localparam count_t     COUNT_MAX = '1;
    localparam out_count_t OUT_MAX   = '1;

    typedef struct packed {
        logic acc;
        logic clr;
    } lane_cmd_t;

    typedef count_t [NUM_LANES-1:0] lane_counts_t;

    // clamp a stored count to the reported width
    function automatic out_count_t report_count(count_t c);
        logic [63:0] wide;
        wide = 64'(c);
        if (wide > 64'(OUT_MAX))
            return OUT_MAX;
        else
            return wide[OUT_W-1:0];
    endfunction

endpackage

[src/rvh_lane.sv]
// one histogram lane: a bin store with per-bin valid flags and saturating update
module rvh_lane (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req,
    input  rvh_pkg::bin_t     addr,
    input  rvh_pkg::lane_cmd_t cmd,
    output rvh_pkg::count_t   count
);

    rvh_pkg::count_t           mem [rvh_pkg::NUM_BINS];
    logic [rvh_pkg::NUM_BINS-1:0] valid_reg;
    rvh_pkg::count_t           rdata_reg;
    logic                      rvalid_reg;
    logic                      pend_reg;
    rvh_pkg::bin_t             addr_reg;
    rvh_pkg::lane_cmd_t        cmd_reg;
    rvh_pkg::count_t           bumped;

    // a bin never written since reset or since its last clear reads as zero
    assign count  = rvalid_reg ? rdata_reg : '0;
    assign bumped = (count == rvh_pkg::COUNT_MAX) ? count : rvh_pkg::count_t'(count + 1'b1);

    always_ff @(posedge clk)
    begin
        if (req)
        begin
            rdata_reg <= mem[addr];
            addr_reg  <= addr;
            cmd_reg   <= cmd;
        end
        if (pend_reg && cmd_reg.acc)
        begin
            mem[addr_reg] <= bumped;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
            pend_reg   <= 1'b0;
        end
        else
        begin
            pend_reg <= req;
            if (req)
            begin
                rvalid_reg <= valid_reg[addr];
            end
            if (pend_reg && cmd_reg.acc)
            begin
                valid_reg[addr_reg] <= 1'b1;
            end
            if (pend_reg && cmd_reg.clr)
            begin
                valid_reg[addr_reg] <= 1'b0;
            end
        end
    end

endmodule

[src/rvh_merge.sv]
// merging stage: gathers the four lane counts into one registered result
module rvh_merge (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  go,
    input  rvh_pkg::bin_t         bin_in,
    input  rvh_pkg::lane_counts_t counts,
    output logic                  strobe,
    output rvh_pkg::bin_t         bin_index,
    output rvh_pkg::out_count_t   red_count,
    output rvh_pkg::out_count_t   green_count,
    output rvh_pkg::out_count_t   blue_count,
    output rvh_pkg::out_count_t   value_count
);

    logic                strobe_reg;
    rvh_pkg::bin_t       bin_reg;
    rvh_pkg::out_count_t red_reg;
    rvh_pkg::out_count_t green_reg;
    rvh_pkg::out_count_t blue_reg;
    rvh_pkg::out_count_t value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= go;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            bin_reg   <= bin_in;
            red_reg   <= rvh_pkg::report_count(counts[rvh_pkg::LANE_RED]);
            green_reg <= rvh_pkg::report_count(counts[rvh_pkg::LANE_GREEN]);
            blue_reg  <= rvh_pkg::report_count(counts[rvh_pkg::LANE_BLUE]);
            value_reg <= rvh_pkg::report_count(counts[rvh_pkg::LANE_VALUE]);
        end
    end

    assign strobe      = strobe_reg;
    assign bin_index   = bin_reg;
    assign red_count   = red_reg;
    assign green_count = green_reg;
    assign blue_count  = blue_reg;
    assign value_count = value_reg;

endmodule

[src/rgb_and_value_histogram_core.sv]
// top level of the rgb and value histogram core
// An item is accepted while start is high and busy is low; its bins are read
// from the lane stores, and busy then stays high while, for an accumulate
// item, every lane writes back its saturated count. That read-modify-write
// through each lane's single-port bin store means no new item is taken
// until the write-back is done. A read item puts its result on the output
// ports for one cycle, marked by strobe, through the lane read registers and
// the merge output registers; the receiver cannot stall it. All counts read
// as zero right after reset through per-bin valid flags, so no clearing pass
// is needed and the block takes items from the first cycle after reset.
module rgb_and_value_histogram_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  rvh_pkg::mode_t      mode,
    input  rvh_pkg::pix_t       red,
    input  rvh_pkg::pix_t       green,
    input  rvh_pkg::pix_t       blue,
    input  rvh_pkg::bin_t       bin,
    output logic                strobe,
    output rvh_pkg::bin_t       bin_index,
    output rvh_pkg::out_count_t red_count,
    output rvh_pkg::out_count_t green_count,
    output rvh_pkg::out_count_t blue_count,
    output rvh_pkg::out_count_t value_count
);

    logic                  busy_reg;
    rvh_pkg::mode_t        mode_reg;
    rvh_pkg::bin_t         bin_reg;
    logic                  accept;
    rvh_pkg::pix_t         max_rg;
    rvh_pkg::pix_t         value;
    rvh_pkg::lane_cmd_t    cmd;
    rvh_pkg::bin_t         lane_addr [rvh_pkg::NUM_LANES];
    rvh_pkg::lane_counts_t counts;

    assign accept = start && !busy_reg;
    assign busy   = busy_reg;

    assign max_rg = (green > red) ? green : red;
    assign value  = (blue > max_rg) ? blue : max_rg;

    assign cmd.acc = (mode == rvh_pkg::MODE_ACC);
    assign cmd.clr = (mode == rvh_pkg::MODE_CLEAR);

    // accumulate hits each channel's own bin, read and clear use the named bin
    always_comb
    begin
        if (mode == rvh_pkg::MODE_ACC)
        begin
            lane_addr[rvh_pkg::LANE_RED]   = red;
            lane_addr[rvh_pkg::LANE_GREEN] = green;
            lane_addr[rvh_pkg::LANE_BLUE]  = blue;
            lane_addr[rvh_pkg::LANE_VALUE] = value;
        end
        else
        begin
            lane_addr[rvh_pkg::LANE_RED]   = bin;
            lane_addr[rvh_pkg::LANE_GREEN] = bin;
            lane_addr[rvh_pkg::LANE_BLUE]  = bin;
            lane_addr[rvh_pkg::LANE_VALUE] = bin;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            mode_reg <= rvh_pkg::MODE_ACC;
        end
        else
        begin
            busy_reg <= accept;
            if (accept)
            begin
                mode_reg <= mode;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            bin_reg <= bin;
        end
    end

    for (genvar i = 0; i < rvh_pkg::NUM_LANES; i++)
    begin : g_lane
        rvh_lane u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .req   (accept),
            .addr  (lane_addr[i]),
            .cmd   (cmd),
            .count (counts[i])
        );
    end

    rvh_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .go          (busy_reg && (mode_reg == rvh_pkg::MODE_READ)),
        .bin_in      (bin_reg),
        .counts      (counts),
        .strobe      (strobe),
        .bin_index   (bin_index),
        .red_count   (red_count),
        .green_count (green_count),
        .blue_count  (blue_count),
        .value_count (value_count)
    );

endmodule

[src/rvh_checker.sv]
// port-level checks for the rgb and value histogram core, bound to the top level
module rvh_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input rvh_pkg::mode_t mode,
    input rvh_pkg::bin_t  bin,
    input logic           strobe,
    input rvh_pkg::bin_t  bin_index
);

    // an accepted item raises busy in the cycle after it, which holds off the next item; busy then drops again
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after an accepted item");

    a_busy_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy)
        else $error("busy held longer than one cycle");

    // every read item gives exactly one result, and each result matches its read item and bin
    a_read_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (mode == rvh_pkg::MODE_READ)) |-> ##2 strobe)
        else $error("read item gave no result");

    a_result_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> ($past(start && !busy, 2) && ($past(mode, 2) == rvh_pkg::MODE_READ)
                    && (bin_index == $past(bin, 2))))
        else $error("result without a matching read item");

    a_result_while_free: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> !busy)
        else $error("result shown while an item is in progress");

endmodule

bind rgb_and_value_histogram_core rvh_checker u_rvh_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .mode      (mode),
    .bin       (bin),
    .strobe    (strobe),
    .bin_index (bin_index)
);

[tb/tb_top.sv]
// self-checking testbench for the rgb and value histogram core
`timescale 1ns / 100ps

module tb_top;

    localparam rvh_pkg::mode_t MODE_UNUSED  = 2'd3;
    localparam int             RANDOM_ITEMS = 1900;
    localparam int             CYCLE_LIMIT  = 200000;

    typedef struct {
        rvh_pkg::mode_t mode;
        rvh_pkg::pix_t  r;
        rvh_pkg::pix_t  g;
        rvh_pkg::pix_t  b;
        rvh_pkg::bin_t  idx;
        int             idle_pct;
        bit             drain;
    } pixel_cmd_t;

    typedef struct {
        rvh_pkg::bin_t       idx;
        rvh_pkg::out_count_t r;
        rvh_pkg::out_count_t g;
        rvh_pkg::out_count_t b;
        rvh_pkg::out_count_t v;
    } bin_report_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    rvh_pkg::mode_t      mode = rvh_pkg::MODE_ACC;
    rvh_pkg::pix_t       red = '0;
    rvh_pkg::pix_t       green = '0;
    rvh_pkg::pix_t       blue = '0;
    rvh_pkg::bin_t       bin = '0;
    logic                strobe;
    rvh_pkg::bin_t       bin_index;
    rvh_pkg::out_count_t red_count;
    rvh_pkg::out_count_t green_count;
    rvh_pkg::out_count_t blue_count;
    rvh_pkg::out_count_t value_count;

    rvh_pkg::count_t red_hist   [rvh_pkg::NUM_BINS] = '{default: '0};
    rvh_pkg::count_t green_hist [rvh_pkg::NUM_BINS] = '{default: '0};
    rvh_pkg::count_t blue_hist  [rvh_pkg::NUM_BINS] = '{default: '0};
    rvh_pkg::count_t value_hist [rvh_pkg::NUM_BINS] = '{default: '0};

    pixel_cmd_t  cmd_q[$];
    bin_report_t report_q[$];
    pixel_cmd_t  next_cmd;
    bin_report_t exp_rep;
    int          total_cmds = 0;
    int          accepted_cmds = 0;
    int          errors = 0;
    int          cycles = 0;

    rgb_and_value_histogram_core u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .mode        (mode),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .bin         (bin),
        .strobe      (strobe),
        .bin_index   (bin_index),
        .red_count   (red_count),
        .green_count (green_count),
        .blue_count  (blue_count),
        .value_count (value_count)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic note_error(input string msg);
        $display("mismatch at cycle %0d: %s", cycles, msg);
        errors++;
    endtask

    function automatic void push_cmd(rvh_pkg::mode_t m, rvh_pkg::pix_t r, rvh_pkg::pix_t g,
                                     rvh_pkg::pix_t b, rvh_pkg::bin_t idx,
                                     int idle_pct, bit drain);
        pixel_cmd_t c;
        c.mode     = m;
        c.r        = r;
        c.g        = g;
        c.b        = b;
        c.idx      = idx;
        c.idle_pct = idle_pct;
        c.drain    = drain;
        cmd_q.push_back(c);
        total_cmds++;
    endfunction

    // saturating increment at the stored count width
    function automatic rvh_pkg::count_t bumped(rvh_pkg::count_t c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    // counts wider than the output port are clamped, not wrapped
    function automatic rvh_pkg::out_count_t clamp_count(rvh_pkg::count_t c);
        return ((c >> 32) != 0) ? '1 : rvh_pkg::out_count_t'(c);
    endfunction

    function automatic void update_histograms(rvh_pkg::mode_t m, rvh_pkg::pix_t r,
                                              rvh_pkg::pix_t g, rvh_pkg::pix_t b,
                                              rvh_pkg::bin_t idx);
        rvh_pkg::pix_t v;
        bin_report_t   rep;
        v = r;
        if (g > v)
            v = g;
        if (b > v)
            v = b;
        case (m)
            rvh_pkg::MODE_ACC:
            begin
                red_hist[r]   = bumped(red_hist[r]);
                green_hist[g] = bumped(green_hist[g]);
                blue_hist[b]  = bumped(blue_hist[b]);
                value_hist[v] = bumped(value_hist[v]);
            end
            rvh_pkg::MODE_READ:
            begin
                rep.idx = idx;
                rep.r   = clamp_count(red_hist[idx]);
                rep.g   = clamp_count(green_hist[idx]);
                rep.b   = clamp_count(blue_hist[idx]);
                rep.v   = clamp_count(value_hist[idx]);
                report_q.push_back(rep);
            end
            rvh_pkg::MODE_CLEAR:
            begin
                red_hist[idx]   = '0;
                green_hist[idx] = '0;
                blue_hist[idx]  = '0;
                value_hist[idx] = '0;
            end
            default:
            begin
            end
        endcase
    endfunction

    // mix of full-range levels, a few hot levels and a cluster of low bins
    function automatic rvh_pkg::pix_t pick_level();
        rvh_pkg::pix_t hot [4] = '{8'd0, 8'd127, 8'd128, 8'd255};
        case ($urandom_range(0, 3))
            0, 1:    return rvh_pkg::pix_t'($urandom_range(0, 255));
            2:       return hot[$urandom_range(0, 3)];
            default: return rvh_pkg::pix_t'($urandom_range(0, 15));
        endcase
    endfunction

    // driver: an item is taken when start is high and busy is low
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            mode  <= rvh_pkg::MODE_ACC;
            red   <= '0;
            green <= '0;
            blue  <= '0;
            bin   <= '0;
        end
        else
        begin
            if (start && !busy)
            begin
                update_histograms(mode, red, green, blue, bin);
                accepted_cmds <= accepted_cmds + 1;
            end
            if (!start || !busy)
            begin
                if (cmd_q.size() == 0)
                    start <= 1'b0;
                else if (cmd_q[0].drain && report_q.size() != 0)
                    start <= 1'b0;
                else if ($urandom_range(0, 99) < cmd_q[0].idle_pct)
                    start <= 1'b0;
                else
                begin
                    next_cmd = cmd_q.pop_front();
                    mode  <= next_cmd.mode;
                    red   <= next_cmd.r;
                    green <= next_cmd.g;
                    blue  <= next_cmd.b;
                    bin   <= next_cmd.idx;
                    start <= 1'b1;
                end
            end
        end
    end

    // monitor: each strobe carries one bin report
    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            if (report_q.size() == 0)
                note_error($sformatf("unexpected result for bin %0d", bin_index));
            else
            begin
                exp_rep = report_q.pop_front();
                if (bin_index !== exp_rep.idx)
                    note_error($sformatf("bin_index got %0d exp %0d", bin_index, exp_rep.idx));
                if (red_count !== exp_rep.r)
                    note_error($sformatf("bin %0d red_count got %0d exp %0d",
                                         exp_rep.idx, red_count, exp_rep.r));
                if (green_count !== exp_rep.g)
                    note_error($sformatf("bin %0d green_count got %0d exp %0d",
                                         exp_rep.idx, green_count, exp_rep.g));
                if (blue_count !== exp_rep.b)
                    note_error($sformatf("bin %0d blue_count got %0d exp %0d",
                                         exp_rep.idx, blue_count, exp_rep.b));
                if (value_count !== exp_rep.v)
                    note_error($sformatf("bin %0d value_count got %0d exp %0d",
                                         exp_rep.idx, value_count, exp_rep.v));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        int            counted;
        int            sel;
        int            idle_by_phase [4];
        rvh_pkg::bin_t rbin;

        idle_by_phase = '{0, 46, 0, 29};

        // directed: empty bins, extreme levels, shared bins, clear, unused mode
        push_cmd(rvh_pkg::MODE_READ, 8'd0, 8'd0, 8'd0, 8'd0, 0, 0);
        push_cmd(rvh_pkg::MODE_READ, 8'd0, 8'd0, 8'd0, 8'd255, 0, 0);
        push_cmd(rvh_pkg::MODE_ACC, 8'd0, 8'd0, 8'd0, 8'd0, 0, 0);
        push_cmd(rvh_pkg::MODE_ACC, 8'd255, 8'd255, 8'd255, 8'd0, 0, 0);
        push_cmd(rvh_pkg::MODE_ACC, 8'd255, 8'd0, 8'd0, 8'd0, 0, 0);
        push_cmd(rvh_pkg::MODE_ACC, 8'd0, 8'd255, 8'd0, 8'd0, 0, 0);
        push_cmd(rvh_pkg::MODE_ACC, 8'd0, 8'd0, 8'd255, 8'd0, 0, 0);
        push_cmd(rvh_pkg::MODE_ACC, 8'd7, 8'd7, 8'd7, 8'd0, 0, 0);
        push_cmd(rvh_pkg::MODE_ACC, 8'd10, 8'd20, 8'd30, 8'd0, 0, 0);
        push_cmd(rvh_pkg::MODE_READ, 8'd0, 8'd0, 8'd0, 8'd0, 0, 0);
        push_cmd(rvh_pkg::MODE_READ, 8'd0, 8'd0, 8'd0, 8'd255, 0, 0);
        push_cmd(rvh_pkg::MODE_READ, 8'd0, 8'd0, 8'd0, 8'd7, 0, 0);
        push_cmd(rvh_pkg::MODE_READ, 8'd0, 8'd0, 8'd0, 8'd10, 0, 0);
        push_cmd(rvh_pkg::MODE_READ, 8'd0, 8'd0, 8'd0, 8'd30, 0, 0);
        push_cmd(rvh_pkg::MODE_CLEAR, 8'd0, 8'd0, 8'd0, 8'd255, 0, 0);
        push_cmd(rvh_pkg::MODE_READ, 8'd0, 8'd0, 8'd0, 8'd255, 0, 0);
        push_cmd(MODE_UNUSED, 8'd255, 8'd255, 8'd255, 8'd0, 0, 0);
        push_cmd(rvh_pkg::MODE_READ, 8'd0, 8'd0, 8'd0, 8'd0, 0, 0);
        // back to back hits on one bin, then read and clear it
        push_cmd(rvh_pkg::MODE_ACC, 8'd5, 8'd5, 8'd5, 8'd0, 0, 0);
        push_cmd(rvh_pkg::MODE_ACC, 8'd5, 8'd5, 8'd5, 8'd0, 0, 0);
        push_cmd(rvh_pkg::MODE_ACC, 8'd5, 8'd4, 8'd3, 8'd0, 0, 0);
        push_cmd(rvh_pkg::MODE_READ, 8'd0, 8'd0, 8'd0, 8'd5, 0, 0);
        push_cmd(rvh_pkg::MODE_CLEAR, 8'd0, 8'd0, 8'd0, 8'd5, 0, 0);
        push_cmd(rvh_pkg::MODE_READ, 8'd0, 8'd0, 8'd0, 8'd5, 0, 0);

        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            sel  = $urandom_range(0, 99);
            rbin = (sel % 2 == 0) ? pick_level() : rvh_pkg::bin_t'($urandom_range(0, 255));
            if (sel < 62)
                push_cmd(rvh_pkg::MODE_ACC, pick_level(), pick_level(), pick_level(),
                         rvh_pkg::bin_t'($urandom_range(0, 255)),
                         idle_by_phase[(counted / 190) % 4], (counted % 400) == 200);
            else if (sel < 90)
                push_cmd(rvh_pkg::MODE_READ, rvh_pkg::pix_t'($urandom_range(0, 255)),
                         rvh_pkg::pix_t'($urandom_range(0, 255)),
                         rvh_pkg::pix_t'($urandom_range(0, 255)),
                         rbin, idle_by_phase[(counted / 190) % 4], (counted % 400) == 200);
            else if (sel < 96)
                push_cmd(rvh_pkg::MODE_CLEAR, rvh_pkg::pix_t'($urandom_range(0, 255)),
                         rvh_pkg::pix_t'($urandom_range(0, 255)),
                         rvh_pkg::pix_t'($urandom_range(0, 255)),
                         rbin, idle_by_phase[(counted / 190) % 4], (counted % 400) == 200);
            else
                push_cmd(MODE_UNUSED, rvh_pkg::pix_t'($urandom_range(0, 255)),
                         rvh_pkg::pix_t'($urandom_range(0, 255)),
                         rvh_pkg::pix_t'($urandom_range(0, 255)),
                         rvh_pkg::bin_t'($urandom_range(0, 255)),
                         idle_by_phase[(counted / 190) % 4], 0);
            if (sel < 96)
                counted++;
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_cmds < total_cmds)
            @(posedge clk);
        while (report_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
